// File: sv/ote_pkg.sv
`timescale 1ns / 1ps

package ote_pkg;

	// Table geometry. The slot of an order is its id modulo the depth, so the
	// depth is a power of two and the slot is the low bits of the id.
	localparam int TABLE_DEPTH = 256;
	localparam int QTY_BITS    = 24;
	localparam int SLOT_BITS   = $clog2(TABLE_DEPTH);
	localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

	// Command queue between the front and the back; depth is a power of two.
	localparam int CMDQ_DEPTH    = 2;
	localparam int CMDQ_PTR_BITS = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_BITS = $clog2(CMDQ_DEPTH + 1);

	// Operation codes on the request port.
	typedef enum logic [1:0] {
		OP_PLACE  = 2'd0,
		OP_CANCEL = 2'd1,
		OP_FILL   = 2'd2
	} op_t;

	// Status codes on the response port.
	typedef enum logic [2:0] {
		ST_PLACED     = 3'd0,
		ST_CANCELLED  = 3'd1,
		ST_PARTIAL    = 3'd2,
		ST_FILLED     = 3'd3,
		ST_NOT_FOUND  = 3'd4,
		ST_TABLE_FULL = 3'd5
	} status_t;

	// Command kinds after classification in the front.
	typedef enum logic [1:0] {
		K_PLACE  = 2'd0,
		K_CANCEL = 2'd1,
		K_FILL   = 2'd2,
		K_NONE   = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		logic [1:0]          operation;
		logic                order_side;
		logic [31:0]         price_ticks;
		logic [QTY_BITS-1:0] order_quantity;
		logic [31:0]         target_id;
		logic [QTY_BITS-1:0] fill_amount;
	} order_in_t;

	typedef struct packed {
		logic [31:0]         result_id;
		logic [2:0]          status_code;
		logic [QTY_BITS-1:0] filled_total;
		logic [QTY_BITS-1:0] total_quantity;
		logic                any_active;
		logic                any_buy_active;
		logic                any_sell_active;
	} order_out_t;

	// Classified command: id is the new id for a place, else the target id.
	typedef struct packed {
		cmd_kind_t            kind;
		logic [SLOT_BITS-1:0] slot;
		logic [31:0]          id;
		logic                 side;
		logic [31:0]          price;
		logic [QTY_BITS-1:0]  qty;
		logic [QTY_BITS-1:0]  amount;
	} cmd_t;

	// Contents of one table slot.
	typedef struct packed {
		logic [31:0]         tag;
		logic                side;
		logic [31:0]         price;
		logic [QTY_BITS-1:0] quantity;
		logic [QTY_BITS-1:0] filled;
	} slot_entry_t;

endpackage

// File: sv/ote_front.sv
`timescale 1ns / 1ps

module ote_front import ote_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  order_in_t request,
	output logic      cmd_push,
	output cmd_t      cmd,
	input  logic      cmd_full
);

	logic [31:0] id_q;
	logic        accept;

	// A transfer happens whenever the command queue has room.
	assign full   = cmd_full;
	assign accept = push && !cmd_full;
	assign cmd_push = accept;

	// Classify the request and resolve its slot.
	always_comb begin
		cmd.side   = request.order_side;
		cmd.price  = request.price_ticks;
		cmd.qty    = request.order_quantity;
		cmd.amount = request.fill_amount;
		cmd.id     = request.target_id;
		cmd.kind   = K_NONE;
		case (request.operation)
			OP_PLACE: begin
				cmd.kind = K_PLACE;
				cmd.id   = id_q;
			end
			OP_CANCEL: cmd.kind = K_CANCEL;
			OP_FILL:   cmd.kind = K_FILL;
			default:   cmd.kind = K_NONE;
		endcase
		cmd.slot = cmd.id[SLOT_BITS-1:0];
	end

	// Every accepted place consumes one id, even if its slot turns out busy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q <= '0;
		end else if (accept && request.operation == OP_PLACE) begin
			id_q <= id_q + 32'd1;
		end
	end

endmodule

// File: sv/ote_cmd_queue.sv
`timescale 1ns / 1ps

module ote_cmd_queue import ote_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_cmd,
	output logic q_full,
	output logic rd_valid,
	output cmd_t rd_cmd,
	input  logic rd_en
);

	cmd_t                     entry_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_BITS-1:0] wr_ptr_q;
	logic [CMDQ_PTR_BITS-1:0] rd_ptr_q;
	logic [CMDQ_CNT_BITS-1:0] count_q;
	logic                     do_wr;
	logic                     do_rd;

	assign q_full   = (count_q == CMDQ_CNT_BITS'(CMDQ_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = entry_q[rd_ptr_q];
	assign do_wr    = wr_en && !q_full;
	assign do_rd    = rd_en && rd_valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + CMDQ_PTR_BITS'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + CMDQ_PTR_BITS'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CMDQ_CNT_BITS'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CMDQ_CNT_BITS'(1);
			end
		end
	end

endmodule

// File: sv/ote_back.sv
`timescale 1ns / 1ps

module ote_back import ote_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  cmd_t       cmd,
	output logic       cmd_pop,
	output logic       empty,
	input  logic       pop,
	output order_out_t response
);

	typedef enum logic [1:0] {
		BK_IDLE = 2'b01,
		BK_EXEC = 2'b10
	} back_state_t;

	back_state_t          state_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	slot_entry_t          mem [TABLE_DEPTH];
	slot_entry_t          rd_q;
	cmd_t                 cur_q;
	logic [CNT_BITS-1:0]  buy_q;
	logic [CNT_BITS-1:0]  sell_q;
	logic [CNT_BITS-1:0]  buy_d;
	logic [CNT_BITS-1:0]  sell_d;
	order_out_t           res_q;
	order_out_t           res_d;
	logic                 res_valid_q;
	logic                 exec;
	logic                 slot_busy;
	logic                 hit;
	logic [QTY_BITS:0]    sum;
	logic                 done;
	logic                 wr_en;
	slot_entry_t          wr_data;
	logic                 set_valid;
	logic                 clr_valid;

	assign exec  = (state_q == BK_EXEC);
	assign empty = !res_valid_q;
	assign response = res_q;

	// Take a command only when the result register will be free for it.
	assign cmd_pop = (state_q == BK_IDLE) && cmd_valid && (!res_valid_q || pop);

	// Slot memory: registered read when a command is taken, write on execute.
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			rd_q  <= mem[cmd.slot];
			cur_q <= cmd;
		end
		if (wr_en) begin
			mem[cur_q.slot] <= wr_data;
		end
	end

	// Match and fill arithmetic on the slot that was read.
	assign slot_busy = valid_q[cur_q.slot];
	assign hit       = slot_busy && (rd_q.tag == cur_q.id);
	assign sum       = {1'b0, rd_q.filled} + {1'b0, cur_q.amount};
	assign done      = (sum >= {1'b0, rd_q.quantity});

	// Carry out the command and build its result.
	always_comb begin
		wr_en     = 1'b0;
		wr_data   = rd_q;
		set_valid = 1'b0;
		clr_valid = 1'b0;
		res_d.result_id      = cur_q.id;
		res_d.status_code    = ST_NOT_FOUND;
		res_d.filled_total   = '0;
		res_d.total_quantity = '0;
		case (cur_q.kind)
			K_PLACE: begin
				res_d.total_quantity = cur_q.qty;
				if (slot_busy) begin
					res_d.status_code = ST_TABLE_FULL;
				end else begin
					wr_en            = exec;
					wr_data.tag      = cur_q.id;
					wr_data.side     = cur_q.side;
					wr_data.price    = cur_q.price;
					wr_data.quantity = cur_q.qty;
					wr_data.filled   = '0;
					set_valid        = exec;
					res_d.status_code = ST_PLACED;
				end
			end
			K_CANCEL: begin
				if (hit) begin
					res_d.filled_total   = rd_q.filled;
					res_d.total_quantity = rd_q.quantity;
					clr_valid            = exec;
					res_d.status_code    = ST_CANCELLED;
				end
			end
			K_FILL: begin
				if (hit) begin
					res_d.total_quantity = rd_q.quantity;
					wr_en                = exec;
					if (done) begin
						res_d.filled_total = rd_q.quantity;
						wr_data.filled     = rd_q.quantity;
						clr_valid          = exec;
						res_d.status_code  = ST_FILLED;
					end else begin
						res_d.filled_total = sum[QTY_BITS-1:0];
						wr_data.filled     = sum[QTY_BITS-1:0];
						res_d.status_code  = ST_PARTIAL;
					end
				end
			end
			default: begin
				res_d.status_code = ST_NOT_FOUND;
			end
		endcase

		// Side counts after this command.
		buy_d  = buy_q;
		sell_d = sell_q;
		if (set_valid) begin
			if (cur_q.side) begin
				sell_d = sell_q + CNT_BITS'(1);
			end else begin
				buy_d = buy_q + CNT_BITS'(1);
			end
		end
		if (clr_valid) begin
			if (rd_q.side) begin
				if (sell_q != '0) begin
					sell_d = sell_q - CNT_BITS'(1);
				end
			end else begin
				if (buy_q != '0) begin
					buy_d = buy_q - CNT_BITS'(1);
				end
			end
		end
		res_d.any_active      = (buy_d != '0) || (sell_d != '0);
		res_d.any_buy_active  = (buy_d != '0);
		res_d.any_sell_active = (sell_d != '0);
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (exec) begin
			res_q <= res_d;
		end
	end

	// Sequencer, valid bits, side counts and result flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			valid_q     <= '0;
			buy_q       <= '0;
			sell_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				BK_IDLE: begin
					if (cmd_pop) begin
						state_q <= BK_EXEC;
					end
				end
				BK_EXEC: state_q <= BK_IDLE;
				default: state_q <= BK_IDLE;
			endcase
			if (set_valid) begin
				valid_q[cur_q.slot] <= 1'b1;
			end
			if (clr_valid) begin
				valid_q[cur_q.slot] <= 1'b0;
			end
			buy_q  <= buy_d;
			sell_q <= sell_d;
			if (exec) begin
				res_valid_q <= 1'b1;
			end else if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// The result register is always free when a command executes.
	assert property (@(posedge clk) disable iff (!arst_n) exec |-> !res_valid_q)
		else $error("result register busy at execute");

	// A taken command executes in the next cycle and then yields a result.
	assert property (@(posedge clk) disable iff (!arst_n) cmd_pop |=> exec)
		else $error("taken command did not execute");

	assert property (@(posedge clk) disable iff (!arst_n) exec |=> res_valid_q)
		else $error("executed command left no result");

	// The side counts always agree with the number of active slots.
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == (32'(buy_q) + 32'(sell_q)))
		else $error("side counts disagree with active slots");

endmodule

// File: sv/order_table_engine.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// request   in         push / full          order_in_t: operation, side, price, qty, id, fill
// response  out        empty / pop          order_out_t: id, status, fill, qty, active flags
//
// The back takes a new command only after the last one has executed: the slot memory
// is read when a command is taken and updated in the execute state, and a command
// is taken only while the result register is free or is being popped.
// The command queue holds up to two commands, so requests are taken while a result waits.
// Reset clears the id counter, the side counts and the slot valid flip-flops at
// once; no clearing pass runs and items are taken right after reset.
module order_table_engine import ote_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  order_in_t  request,
	output logic       empty,
	input  logic       pop,
	output order_out_t response
);

	logic cmd_push;
	cmd_t front_cmd;
	logic cmd_full;
	logic cmd_valid;
	cmd_t queue_cmd;
	logic cmd_pop;

	// Front: accepts requests, assigns ids and resolves slots.
	ote_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.request  (request),
		.cmd_push (cmd_push),
		.cmd      (front_cmd),
		.cmd_full (cmd_full)
	);

	// Command queue between front and back.
	ote_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cmd_push),
		.wr_cmd   (front_cmd),
		.q_full   (cmd_full),
		.rd_valid (cmd_valid),
		.rd_cmd   (queue_cmd),
		.rd_en    (cmd_pop)
	);

	// Back: slot table, side counts and result register.
	ote_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (queue_cmd),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.response  (response)
	);

endmodule

// File: tb/tb_order_table_engine.sv
`timescale 1ns / 1ps

module tb_order_table_engine;
	import ote_pkg::*;

	// Worst correct run: about 1670 items, each with a sender gap, the back-end
	// execution and a receiver stall; the limit leaves wide margin over that sum.
	localparam int unsigned CYCLE_LIMIT  = 800000;
	localparam int unsigned RANDOM_ITEMS = 1650;
	localparam int unsigned SETTLE_CYCLES = 20;

	// Operation code that the block answers as not found.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef enum {MIX_BUILD, MIX_EVEN, MIX_DRAIN} mix_t;
	typedef enum {POP_ALWAYS, POP_HALF, POP_SPARSE, POP_HOLD} pop_mode_t;

	// Order table mirror: predicts one response per accepted request.
	class order_book_model;
		bit                live[TABLE_DEPTH];
		bit [31:0]         tag[TABLE_DEPTH];
		bit                sell_side[TABLE_DEPTH];
		bit [31:0]         price[TABLE_DEPTH];
		bit [QTY_BITS-1:0] quantity[TABLE_DEPTH];
		bit [QTY_BITS-1:0] filled[TABLE_DEPTH];
		bit [31:0]         next_id;
		int unsigned       buys;
		int unsigned       sells;
		int unsigned       errors;
		order_out_t        pending_results[$];

		function void free_slot(bit [SLOT_BITS-1:0] s);
			live[s] = 1'b0;
			if (sell_side[s]) begin
				if (sells > 0) sells--;
			end else begin
				if (buys > 0) buys--;
			end
		endfunction

		function void note_input(order_in_t req);
			order_out_t         rsp;
			bit [SLOT_BITS-1:0] s;
			bit [QTY_BITS:0]    sum;
			rsp = '0;
			rsp.result_id = req.target_id;
			rsp.status_code = ST_NOT_FOUND;
			s = req.target_id[SLOT_BITS-1:0];
			case (req.operation)
				OP_PLACE: begin
					s = next_id[SLOT_BITS-1:0];
					rsp.result_id = next_id;
					rsp.total_quantity = req.order_quantity;
					next_id++;
					if (live[s]) begin
						rsp.status_code = ST_TABLE_FULL;
					end else begin
						live[s] = 1'b1;
						tag[s] = rsp.result_id;
						sell_side[s] = req.order_side;
						price[s] = req.price_ticks;
						quantity[s] = req.order_quantity;
						filled[s] = '0;
						if (req.order_side) sells++;
						else buys++;
						rsp.status_code = ST_PLACED;
					end
				end
				OP_CANCEL: begin
					if (live[s] && tag[s] == req.target_id) begin
						rsp.filled_total = filled[s];
						rsp.total_quantity = quantity[s];
						free_slot(s);
						rsp.status_code = ST_CANCELLED;
					end
				end
				OP_FILL: begin
					if (live[s] && tag[s] == req.target_id) begin
						sum = {1'b0, filled[s]} + {1'b0, req.fill_amount};
						rsp.total_quantity = quantity[s];
						// Fills at or past the quantity clamp and retire the order.
						if (sum >= {1'b0, quantity[s]}) begin
							filled[s] = quantity[s];
							free_slot(s);
							rsp.status_code = ST_FILLED;
						end else begin
							filled[s] = sum[QTY_BITS-1:0];
							rsp.status_code = ST_PARTIAL;
						end
						rsp.filled_total = filled[s];
					end
				end
				default: begin
				end
			endcase
			rsp.any_active = (buys + sells) != 0;
			rsp.any_buy_active = buys != 0;
			rsp.any_sell_active = sells != 0;
			pending_results.push_back(rsp);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s expected %h actual %h", $time, name, want, got);
			end
		endfunction

		function void check_result(order_out_t got);
			order_out_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: response expected none actual %h", $time, got);
				return;
			end
			want = pending_results.pop_front();
			compare_field("result_id", want.result_id, got.result_id);
			compare_field("status_code", 32'(want.status_code), 32'(got.status_code));
			compare_field("filled_total", 32'(want.filled_total), 32'(got.filled_total));
			compare_field("total_quantity", 32'(want.total_quantity),
				32'(got.total_quantity));
			compare_field("any_active", 32'(want.any_active), 32'(got.any_active));
			compare_field("any_buy_active", 32'(want.any_buy_active),
				32'(got.any_buy_active));
			compare_field("any_sell_active", 32'(want.any_sell_active),
				32'(got.any_sell_active));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	order_in_t   request = '0;
	logic        empty;
	logic        pop = 1'b0;
	order_out_t  response;
	int unsigned cycles = 0;

	order_book_model book;

	// Stimulus-side view of issued ids; quantities are kept per slot.
	bit [31:0]         gen_next_id = '0;
	bit [QTY_BITS-1:0] gen_qty[TABLE_DEPTH];

	order_table_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.request  (request),
		.empty    (empty),
		.pop      (pop),
		.response (response)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Both ports are sampled with their pre-edge values at each rising edge.
	always @(posedge clk) begin
		if (push && !full) book.note_input(request);
		if (pop && !empty) book.check_result(response);
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("order_table_engine: mismatch");
			$finish;
		end
	end

	// The receiver alternates between steady draining, random pops and hard stalls.
	initial begin : receiver
		pop_mode_t   mode;
		int unsigned run_len;
		forever begin
			mode = pop_mode_t'($urandom_range(0, 3));
			run_len = $urandom_range(5, 60);
			repeat (run_len) begin
				@(posedge clk);
				case (mode)
					POP_ALWAYS: pop <= 1'b1;
					POP_HALF:   pop <= 1'($urandom_range(0, 1));
					POP_SPARSE: pop <= ($urandom_range(0, 3) == 0);
					default:    pop <= 1'b0;
				endcase
			end
		end
	end

	function automatic order_in_t make_place(bit side, bit [31:0] px, bit [QTY_BITS-1:0] qty);
		order_in_t it;
		it.operation = OP_PLACE;
		it.order_side = side;
		it.price_ticks = px;
		it.order_quantity = qty;
		it.target_id = $urandom;
		it.fill_amount = QTY_BITS'($urandom);
		gen_qty[gen_next_id[SLOT_BITS-1:0]] = qty;
		gen_next_id++;
		return it;
	endfunction

	function automatic order_in_t make_ref(logic [1:0] op, bit [31:0] target,
			bit [QTY_BITS-1:0] amount);
		order_in_t it;
		it.operation = op;
		it.order_side = 1'($urandom_range(0, 1));
		it.price_ticks = $urandom;
		it.order_quantity = QTY_BITS'($urandom);
		it.target_id = target;
		it.fill_amount = amount;
		return it;
	endfunction

	// Mostly well-formed traffic on recent orders, with stale and random ids mixed in.
	function automatic order_in_t random_item(mix_t mix);
		int unsigned       r;
		int unsigned       place_pct;
		int unsigned       cancel_pct;
		int unsigned       fill_pct;
		int unsigned       span;
		bit [31:0]         target;
		bit [QTY_BITS-1:0] q;
		bit [QTY_BITS-1:0] amount;
		logic [1:0]        op;
		case (mix)
			MIX_BUILD: begin
				place_pct = 85; cancel_pct = 5; fill_pct = 8;
			end
			MIX_EVEN: begin
				place_pct = 40; cancel_pct = 25; fill_pct = 32;
			end
			default: begin
				place_pct = 10; cancel_pct = 40; fill_pct = 47;
			end
		endcase
		r = $urandom_range(0, 99);
		if (r < place_pct) begin
			r = $urandom_range(0, 99);
			if (r < 65) q = QTY_BITS'($urandom_range(1, 200));
			else if (r < 75) q = '0;
			else if (r < 88) q = QTY_BITS'($urandom);
			else q = QTY_BITS'({QTY_BITS{1'b1}} - $urandom_range(0, 3));
			return make_place(1'($urandom_range(0, 1)), $urandom, q);
		end
		if (r < place_pct + cancel_pct) op = OP_CANCEL;
		else if (r < place_pct + cancel_pct + fill_pct) op = OP_FILL;
		else op = OP_UNUSED;

		span = (gen_next_id < TABLE_DEPTH) ? gen_next_id : TABLE_DEPTH;
		r = $urandom_range(0, 99);
		if (span == 0 || r >= 85) target = $urandom;
		else if (r < 70) target = gen_next_id - 1 - $urandom_range(0, span - 1);
		else if (r < 80) target = gen_next_id - 1 - $urandom_range(0, span - 1)
				+ TABLE_DEPTH * $urandom_range(1, 3);
		else target = gen_next_id + $urandom_range(0, 3);

		q = gen_qty[target[SLOT_BITS-1:0]];
		r = $urandom_range(0, 99);
		if (r < 45) amount = QTY_BITS'($urandom_range(0, q / 4));
		else if (r < 70) amount = QTY_BITS'($urandom_range(0, q));
		else if (r < 85) amount = q;
		else amount = QTY_BITS'($urandom);
		return make_ref(op, target, amount);
	endfunction

	// Present one request and hold it until the block takes it.
	task automatic send_order(input order_in_t item);
		push <= 1'b1;
		request <= item;
		do @(posedge clk); while (full);
	endtask

	task automatic hold_off(input int unsigned n);
		push <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Stop sending until every outstanding response has been checked.
	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (book.pending_results.size() != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic run_directed();
		bit [31:0] a, b, c, d, e;
		// A zero quantity order completes on a fill of zero.
		send_order(make_place(1'b0, 32'h0, '0));
		a = gen_next_id - 1;
		send_order(make_ref(OP_FILL, a, '0));
		// Largest quantity: partial fill, then a fill past it clamps.
		send_order(make_place(1'b1, 32'hFFFF_FFFF, {QTY_BITS{1'b1}}));
		b = gen_next_id - 1;
		send_order(make_ref(OP_FILL, b, {{(QTY_BITS-1){1'b1}}, 1'b0}));
		send_order(make_ref(OP_FILL, b, {QTY_BITS{1'b1}}));
		send_order(make_ref(OP_FILL, b, QTY_BITS'(1)));
		// Same slot with another id is not a match.
		send_order(make_place(1'b0, 32'h8000_0001, QTY_BITS'(10)));
		c = gen_next_id - 1;
		send_order(make_ref(OP_CANCEL, c + TABLE_DEPTH, '0));
		send_order(make_ref(OP_FILL, c, QTY_BITS'(3)));
		send_order(make_ref(OP_CANCEL, c, '0));
		send_order(make_ref(OP_CANCEL, c, '0));
		send_order(make_ref(OP_UNUSED, $urandom, QTY_BITS'($urandom)));
		// One order per side, then retire them in turn.
		send_order(make_place(1'b1, 32'd5000, QTY_BITS'(5)));
		d = gen_next_id - 1;
		send_order(make_place(1'b0, 32'd4999, QTY_BITS'(7)));
		e = gen_next_id - 1;
		send_order(make_ref(OP_FILL, d, QTY_BITS'(5)));
		send_order(make_ref(OP_CANCEL, 32'hFFFF_FFFF, {QTY_BITS{1'b1}}));
		send_order(make_ref(OP_FILL, e, '0));
		send_order(make_ref(OP_UNUSED, e, QTY_BITS'(7)));
		send_order(make_ref(OP_FILL, e, {QTY_BITS{1'b1}}));
	endtask

	initial begin : stimulus
		int unsigned sent;
		int unsigned burst;
		int unsigned k;
		int unsigned mix_left;
		bit          paused;
		mix_t        mix;
		book = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		wait_drained();

		// Open with a long build-up so the table wraps onto live slots.
		sent = 0;
		paused = 1'b0;
		mix = MIX_BUILD;
		mix_left = 350;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 40);
			for (k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
				if (mix_left == 0) begin
					mix = mix_t'($urandom_range(0, 2));
					mix_left = $urandom_range(100, 200);
				end
				send_order(random_item(mix));
				sent++;
				mix_left--;
			end
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				wait_drained();
				paused = 1'b1;
			end else if ($urandom_range(0, 7) == 0) begin
				hold_off($urandom_range(10, 30));
			end else if ($urandom_range(0, 2) != 0) begin
				hold_off($urandom_range(1, 6));
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (book.errors == 0 && book.pending_results.size() == 0) begin
			$display("order_table_engine: match");
		end else begin
			$display("order_table_engine: mismatch");
		end
		$finish;
	end

endmodule

// File: filelist.f
sv/ote_pkg.sv
sv/ote_front.sv
sv/ote_cmd_queue.sv
sv/ote_back.sv
sv/order_table_engine.sv
tb/tb_order_table_engine.sv
